>>> hdl/egd_pkg.sv
// Shared types and constants for the elevator group dispatcher.
// No dependencies; used by egd_ctrl, egd_datapath and the top level.
package egd_pkg;

	localparam int NUM_CARS_DEF   = 5;
	localparam int NUM_FLOORS_DEF = 20;

	localparam int CAR_W   = 3;
	localparam int FLOOR_W = 5;
	localparam int WGT_W   = 10;
	localparam int POP_W   = 5;
	localparam int PROD_W  = FLOOR_W + WGT_W;
	localparam int COST_W  = PROD_W + 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam logic [CAR_W-1:0] NO_OWNER = 3'd7;

	localparam logic [WGT_W-1:0] DIST_W_RST   = 10'd10;
	localparam logic [WGT_W-1:0] BEHIND_RST   = 10'd100;
	localparam logic [WGT_W-1:0] OPPOSITE_RST = 10'd200;
	localparam logic [WGT_W-1:0] LOAD_W_RST   = 10'd30;

	typedef enum logic [1:0] {
		REG_DIST_W   = 2'd0,
		REG_BEHIND   = 2'd1,
		REG_OPPOSITE = 2'd2,
		REG_LOAD_W   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_HALL_CALL   = 2'd0,
		OP_HALL_CANCEL = 2'd1,
		OP_CAR_CALL    = 2'd2,
		OP_TICK        = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		HEAD_STOP = 2'd0,
		HEAD_UP   = 2'd1,
		HEAD_DOWN = 2'd2
	} head_t;

	typedef enum logic [1:0] {
		RS_DONE      = 2'd0,
		RS_ASSIGNED  = 2'd1,
		RS_NO_CANCEL = 2'd2,
		RS_INVALID   = 2'd3
	} rstat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_HALL,
		S_PK_A,
		S_PK_B,
		S_PK_C,
		S_ASSIGN,
		S_TRD,
		S_TSTEP,
		S_OUT
	} state_t;

	typedef struct packed {
		logic ld_req;
		logic cnt_clr;
		logic cnt_inc;
		logic rd_req_row;
		logic rd_tick_row;
		logic emit_invalid;
		logic do_car_call;
		logic do_hall;
		logic pk_a;
		logic pk_b;
		logic pk_c;
		logic do_assign;
		logic do_tick;
	} egd_cmd_t;

	typedef struct packed {
		op_t  op;
		logic req_invalid;
		logic owner_valid;
		logic cnt_last;
		logic out_done;
	} egd_sts_t;

endpackage

>>> hdl/elevator_group_dispatcher_top.sv
// Elevator group dispatcher: hall call cost dispatch and SCAN travel per tick.
// Hall call: decode, owner table read, then steps PK_A, PK_B, PK_C for each car in turn.
// Cancel or already owned call: decode and owner table read; car call, invalid request: decode.
// Tick: decode, then per car a hall row read and a step to the result register plus its transfer.
// One request at a time; async reset clears car state and owner valid bits.
module elevator_group_dispatcher_top #(
	parameter int NUM_CARS   = egd_pkg::NUM_CARS_DEF,
	parameter int NUM_FLOORS = egd_pkg::NUM_FLOORS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// floor[4:0], hall_dir[5], car[8:6]
	input  logic [egd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// op[1:0]
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// car_index[2:0], car_floor[7:3], car_heading[9:8], status[11:10],
	// served_floor[16:12], up_call_cleared[17], down_call_cleared[18]
	output logic [egd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_addr,
	input  logic [egd_pkg::WGT_W-1:0]         cfg_wdata
);
	import egd_pkg::*;

	egd_cmd_t cmd;
	egd_sts_t sts;

	logic [CAR_W-1:0]   out_car;
	logic [FLOOR_W-1:0] out_floor, out_served;
	logic [1:0]         out_head, out_status;
	logic               out_upc, out_dnc;

	egd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	egd_datapath #(
		.NUM_CARS   (NUM_CARS),
		.NUM_FLOORS (NUM_FLOORS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (s_axis_tuser),
		.in_floor   (s_axis_tdata[4:0]),
		.in_dir     (s_axis_tdata[5]),
		.in_car     (s_axis_tdata[8:6]),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_car    (out_car),
		.out_floor  (out_floor),
		.out_head   (out_head),
		.out_status (out_status),
		.out_served (out_served),
		.out_upc    (out_upc),
		.out_dnc    (out_dnc),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, out_dnc, out_upc, out_served, out_status,
		out_head, out_floor, out_car};

endmodule

>>> hdl/egd_ctrl.sv
// Sequencer for the dispatcher: decodes a request and steps the datapath.
// Depends on egd_pkg.
module egd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  egd_pkg::egd_sts_t sts,
	output egd_pkg::egd_cmd_t cmd
);
	import egd_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_req  = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.op == OP_TICK) begin
					state_d = S_TRD;
				end else if (sts.req_invalid) begin
					cmd.emit_invalid = 1'b1;
					state_d          = S_OUT;
				end else if (sts.op == OP_CAR_CALL) begin
					cmd.do_car_call = 1'b1;
					state_d         = S_OUT;
				end else begin
					cmd.rd_req_row = 1'b1;
					state_d        = S_HALL;
				end
			end
			S_HALL: begin
				if (sts.op == OP_HALL_CALL && !sts.owner_valid) begin
					state_d = S_PK_A;
				end else begin
					cmd.do_hall = 1'b1;
					state_d     = S_OUT;
				end
			end
			S_PK_A: begin
				cmd.pk_a = 1'b1;
				state_d  = S_PK_B;
			end
			S_PK_B: begin
				cmd.pk_b = 1'b1;
				state_d  = S_PK_C;
			end
			S_PK_C: begin
				cmd.pk_c = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_ASSIGN;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d     = S_PK_A;
				end
			end
			S_ASSIGN: begin
				cmd.do_assign = 1'b1;
				state_d       = S_OUT;
			end
			S_TRD: begin
				cmd.rd_tick_row = 1'b1;
				state_d         = S_TSTEP;
			end
			S_TSTEP: begin
				cmd.do_tick = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (sts.out_done) begin
					if (sts.op == OP_TICK && !sts.cnt_last) begin
						cmd.cnt_inc = 1'b1;
						state_d     = S_TRD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_invalid, cmd.do_car_call, cmd.do_hall, cmd.do_assign, cmd.do_tick}))
		else $error("two result sources in one cycle");

	a_out_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_tick || cmd.do_assign) |=> state_q == S_OUT)
		else $error("result issued without waiting for transfer");

endmodule

>>> hdl/egd_datapath.sv
// Car state, hall call owner table, cost unit and result register.
// Depends on egd_pkg; driven by egd_ctrl.
module egd_datapath #(
	parameter int NUM_CARS   = egd_pkg::NUM_CARS_DEF,
	parameter int NUM_FLOORS = egd_pkg::NUM_FLOORS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  egd_pkg::egd_cmd_t             cmd,
	output egd_pkg::egd_sts_t             sts,
	input  logic [1:0]                    in_op,
	input  logic [egd_pkg::FLOOR_W-1:0]   in_floor,
	input  logic                          in_dir,
	input  logic [egd_pkg::CAR_W-1:0]     in_car,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_addr,
	input  logic [egd_pkg::WGT_W-1:0]     cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [egd_pkg::CAR_W-1:0]     out_car,
	output logic [egd_pkg::FLOOR_W-1:0]   out_floor,
	output logic [1:0]                    out_head,
	output logic [1:0]                    out_status,
	output logic [egd_pkg::FLOOR_W-1:0]   out_served,
	output logic                          out_upc,
	output logic                          out_dnc,
	output logic                          out_last
);
	import egd_pkg::*;

	localparam int CIDX_W = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
	localparam int FIDX_W = $clog2(NUM_FLOORS);
	localparam logic [CIDX_W-1:0] LAST_CAR = CIDX_W'(NUM_CARS - 1);

	// configuration
	logic [WGT_W-1:0] dist_w_q, behind_q, opp_q, load_w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_w_q <= DIST_W_RST;
			behind_q <= BEHIND_RST;
			opp_q    <= OPPOSITE_RST;
			load_w_q <= LOAD_W_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_DIST_W:   dist_w_q <= cfg_wdata;
				REG_BEHIND:   behind_q <= cfg_wdata;
				REG_OPPOSITE: opp_q    <= cfg_wdata;
				REG_LOAD_W:   load_w_q <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	// latched request
	op_t                req_op_q;
	logic [FLOOR_W-1:0] req_floor_q;
	logic               req_dir_q;
	logic [CAR_W-1:0]   req_car_q;

	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			req_op_q    <= op_t'(in_op);
			req_floor_q <= in_floor;
			req_dir_q   <= in_dir;
			req_car_q   <= in_car;
		end
	end

	// car state
	logic [FLOOR_W-1:0]    pos_q  [NUM_CARS];
	head_t                 head_q [NUM_CARS];
	logic [NUM_FLOORS-1:0] tmap_q [NUM_CARS];
	logic [CIDX_W-1:0]     cnt_q, best_q;
	logic [COST_W-1:0]     best_cost_q;

	// hall owner table: one row per floor, {down owner, up owner}
	logic [2*CAR_W-1:0] hall_mem [NUM_FLOORS];
	logic [NUM_FLOORS-1:0] hall_vld_q;
	logic [2*CAR_W-1:0] rd_q;
	logic               rd_vld_q;
	logic [FIDX_W-1:0]  row_q;
	logic               rd_en, wr_en;
	logic [FIDX_W-1:0]  rd_addr;
	logic [2*CAR_W-1:0] wr_row;

	logic [FLOOR_W-1:0] req_idx, tick_idx;
	logic [FIDX_W-1:0]  req_row, tick_row;
	logic [CAR_W-1:0]   own_up, own_dn, slot_owner, cnt_ext;
	logic               owner_valid, floor_ok, req_invalid;

	assign req_idx  = req_floor_q - FLOOR_W'(1);
	assign req_row  = req_idx[FIDX_W-1:0];
	assign tick_idx = pos_q[cnt_q] - FLOOR_W'(1);
	assign tick_row = tick_idx[FIDX_W-1:0];
	assign rd_en    = cmd.rd_req_row || cmd.rd_tick_row;
	assign rd_addr  = cmd.rd_tick_row ? tick_row : req_row;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q     <= hall_mem[rd_addr];
			rd_vld_q <= hall_vld_q[rd_addr];
			row_q    <= rd_addr;
		end
		if (wr_en) begin
			hall_mem[row_q] <= wr_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hall_vld_q <= '0;
		end else if (wr_en) begin
			hall_vld_q[row_q] <= 1'b1;
		end
	end

	assign own_up      = rd_vld_q ? rd_q[CAR_W-1:0] : NO_OWNER;
	assign own_dn      = rd_vld_q ? rd_q[2*CAR_W-1:CAR_W] : NO_OWNER;
	assign slot_owner  = req_dir_q ? own_dn : own_up;
	assign owner_valid = {1'b0, slot_owner} < (CAR_W+1)'(NUM_CARS);
	assign cnt_ext     = CAR_W'(cnt_q);

	assign floor_ok = (req_floor_q != '0) && (req_floor_q <= FLOOR_W'(NUM_FLOORS));
	always_comb begin
		if (req_op_q == OP_CAR_CALL) begin
			req_invalid = !floor_ok || ({1'b0, req_car_q} >= (CAR_W+1)'(NUM_CARS));
		end else begin
			req_invalid = !floor_ok
				|| (!req_dir_q && req_floor_q == FLOOR_W'(NUM_FLOORS))
				|| (req_dir_q && req_floor_q == FLOOR_W'(1));
		end
	end

	// selected car and its next state
	logic [CIDX_W-1:0]     sel;
	logic [FLOOR_W-1:0]    p, p_tick;
	head_t                 h, h_add, h_dir, h_tick;
	logic [NUM_FLOORS-1:0] tm, f_bit, cur_bit, tm_tick, above, below;
	logic                  upc, dnc;

	always_comb begin
		sel = cnt_q;
		if (cmd.do_car_call) sel = req_car_q[CIDX_W-1:0];
		if (cmd.do_assign)   sel = best_q;
		if (cmd.do_hall)     sel = slot_owner[CIDX_W-1:0];
	end

	assign p     = pos_q[sel];
	assign h     = head_q[sel];
	assign tm    = tmap_q[sel];
	assign f_bit = NUM_FLOORS'(1) << req_idx;

	always_comb begin
		h_add = h;
		if (h == HEAD_STOP) begin
			if (req_floor_q > p)      h_add = HEAD_UP;
			else if (req_floor_q < p) h_add = HEAD_DOWN;
		end
	end

	assign cur_bit = NUM_FLOORS'(1) << (p - FLOOR_W'(1));
	assign tm_tick = tm & ~cur_bit;
	assign above   = tm_tick & ~((cur_bit << 1) - NUM_FLOORS'(1));
	assign below   = tm_tick & (cur_bit - NUM_FLOORS'(1));
	assign upc     = (p < FLOOR_W'(NUM_FLOORS)) && (own_up == cnt_ext);
	assign dnc     = (p > FLOOR_W'(1)) && (own_dn == cnt_ext);

	// SCAN: keep going while targets lie ahead, else turn; from rest go down if any target lies below, else up
	always_comb begin
		h_dir = h;
		if (tm_tick == '0) begin
			h_dir = HEAD_STOP;
		end else if ((h == HEAD_UP && above != '0) || (h == HEAD_DOWN && below != '0)) begin
			h_dir = h;
		end else if (h == HEAD_UP && below != '0) begin
			h_dir = HEAD_DOWN;
		end else if (h == HEAD_DOWN && above != '0) begin
			h_dir = HEAD_UP;
		end else if (h == HEAD_STOP) begin
			h_dir = (below != '0) ? HEAD_DOWN : HEAD_UP;
		end
		h_tick = h_dir;
		p_tick = p;
		if (h_dir == HEAD_UP) begin
			if (p < FLOOR_W'(NUM_FLOORS)) p_tick = p + FLOOR_W'(1);
			else                          h_tick = HEAD_STOP;
		end else if (h_dir == HEAD_DOWN) begin
			if (p > FLOOR_W'(1)) p_tick = p - FLOOR_W'(1);
			else                 h_tick = HEAD_STOP;
		end
	end

	// hall table write-back
	logic hall_cancel;
	assign hall_cancel = cmd.do_hall && req_op_q == OP_HALL_CANCEL && owner_valid;

	always_comb begin
		wr_en  = 1'b0;
		wr_row = {own_dn, own_up};
		if (cmd.do_assign) begin
			wr_en = 1'b1;
			if (req_dir_q) wr_row[2*CAR_W-1:CAR_W] = CAR_W'(best_q);
			else           wr_row[CAR_W-1:0]       = CAR_W'(best_q);
		end else if (hall_cancel) begin
			wr_en = 1'b1;
			if (req_dir_q) wr_row[2*CAR_W-1:CAR_W] = NO_OWNER;
			else           wr_row[CAR_W-1:0]       = NO_OWNER;
		end else if (cmd.do_tick) begin
			wr_en = 1'b1;
			if (upc) wr_row[CAR_W-1:0]       = NO_OWNER;
			if (dnc) wr_row[2*CAR_W-1:CAR_W] = NO_OWNER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CARS; i++) begin
				pos_q[i]  <= FLOOR_W'(1);
				head_q[i] <= HEAD_STOP;
				tmap_q[i] <= '0;
			end
		end else begin
			if (cmd.do_car_call || cmd.do_assign) begin
				tmap_q[sel] <= tm | f_bit;
				head_q[sel] <= h_add;
			end else if (hall_cancel) begin
				tmap_q[sel] <= tm & ~f_bit;
			end else if (cmd.do_tick) begin
				tmap_q[sel] <= tm_tick;
				head_q[sel] <= h_tick;
				pos_q[sel]  <= p_tick;
			end
		end
	end

	// cost unit: three steps per car
	logic [FLOOR_W-1:0] dist_s1;
	logic [POP_W-1:0]   pop_s1, pop_c;
	logic [WGT_W-1:0]   pen_s1, pen_c, pen_s2;
	logic [PROD_W-1:0]  prod_d_s2, prod_l_s2;
	logic [COST_W-1:0]  cost;
	head_t              want;

	assign want = req_dir_q ? HEAD_DOWN : HEAD_UP;

	always_comb begin
		pop_c = '0;
		for (int b = 0; b < NUM_FLOORS; b++) begin
			pop_c = pop_c + POP_W'(tm[b]);
		end
		pen_c = '0;
		if (h == HEAD_STOP) begin
			pen_c = '0;
		end else if (h == want) begin
			if ((want == HEAD_UP) ? (req_floor_q < p) : (req_floor_q > p)) pen_c = behind_q;
		end else begin
			pen_c = opp_q;
		end
	end

	assign cost = COST_W'(prod_d_s2) + COST_W'(prod_l_s2) + COST_W'(pen_s2);

	always_ff @(posedge clk) begin
		if (cmd.pk_a) begin
			dist_s1 <= (p > req_floor_q) ? p - req_floor_q : req_floor_q - p;
			pop_s1  <= pop_c;
			pen_s1  <= pen_c;
		end
		if (cmd.pk_b) begin
			prod_d_s2 <= PROD_W'(dist_s1 * dist_w_q);
			prod_l_s2 <= PROD_W'(pop_s1 * load_w_q);
			pen_s2    <= pen_s1;
		end
		if (cmd.pk_c && (cnt_q == '0 || cost < best_cost_q)) begin
			best_cost_q <= cost;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			best_q <= '0;
		end else begin
			if (cmd.cnt_clr)      cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + CIDX_W'(1);
			if (cmd.pk_c && (cnt_q == '0 || cost < best_cost_q)) best_q <= cnt_q;
		end
	end

	// result register
	logic out_valid_q;
	logic emit;
	assign emit = cmd.emit_invalid || cmd.do_car_call || cmd.do_hall
		|| cmd.do_assign || cmd.do_tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_car    <= CAR_W'(sel);
			out_floor  <= p;
			out_head   <= h;
			out_status <= RS_DONE;
			out_served <= '0;
			out_upc    <= 1'b0;
			out_dnc    <= 1'b0;
			out_last   <= 1'b1;
			if (cmd.emit_invalid) begin
				out_car    <= '0;
				out_floor  <= '0;
				out_head   <= HEAD_STOP;
				out_status <= RS_INVALID;
			end else if (cmd.do_car_call || cmd.do_assign) begin
				out_head <= h_add;
			end else if (cmd.do_hall) begin
				if (!owner_valid) begin
					out_car    <= '0;
					out_floor  <= '0;
					out_head   <= HEAD_STOP;
					out_status <= RS_NO_CANCEL;
				end else if (req_op_q == OP_HALL_CALL) begin
					out_status <= RS_ASSIGNED;
				end
			end else begin
				out_floor  <= p_tick;
				out_head   <= h_tick;
				out_served <= p;
				out_upc    <= upc;
				out_dnc    <= dnc;
				out_last   <= cnt_q == LAST_CAR;
			end
		end
	end

	assign out_valid = out_valid_q;

	assign sts.op          = req_op_q;
	assign sts.req_invalid = req_invalid;
	assign sts.owner_valid = owner_valid;
	assign sts.cnt_last    = cnt_q == LAST_CAR;
	assign sts.out_done    = out_valid_q && out_ready;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !out_valid_q)
		else $error("result register overwritten");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cnt_q} <= (CIDX_W+1)'(NUM_CARS - 1))
		else $error("car counter out of range");

	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pk_c |=> {1'b0, best_q} <= (CIDX_W+1)'(NUM_CARS - 1))
		else $error("picked car out of range");

endmodule

>>> dv/tb.sv
// Testbench for elevator_group_dispatcher_top: directed table then random phases.
// Self-contained predictor of car state and hall owners; depends on egd_pkg and elevator_group_dispatcher_top.
`timescale 1ns / 1ps

module tb;
	import egd_pkg::*;

	localparam int NC = NUM_CARS_DEF;
	localparam int NF = NUM_FLOORS_DEF;
	localparam int WD_LIMIT = 20000;

	typedef struct packed {
		logic [2:0] car_index;
		logic [4:0] car_floor;
		logic [1:0] heading;
		logic [1:0] status;
		logic [4:0] served;
		logic       upc;
		logic       dnc;
		logic       last;
	} car_result_t;

	typedef struct {
		op_t        op;
		logic [4:0] fl;
		logic       dir;
		logic [2:0] car;
		bit         typed;
		car_result_t res;
	} req_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tready = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_addr = '0;
	logic [WGT_W-1:0] cfg_wdata = '0;
	wire s_axis_tready;
	wire m_axis_tvalid;
	wire [OUT_DATA_W-1:0] m_axis_tdata;
	wire m_axis_tlast;

	elevator_group_dispatcher_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// predictor state
	int wdist, wbehind, wopp, wload;
	logic [4:0]  car_pos [NC];
	logic [1:0]  car_head [NC];
	logic [31:0] car_targets [NC];
	int          hall_owner [2*NF];

	car_result_t pending_results [$];
	req_row_t    dir_rows [$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_start = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	function automatic logic [31:0] floor_bit(input logic [4:0] f);
		return 32'd1 << ((f - 5'd1) & 5'd31);
	endfunction

	function automatic int pop_count(input logic [31:0] v);
		int n;
		n = 0;
		for (int b = 0; b < 32; b++)
			n += v[b];
		return n;
	endfunction

	function automatic void push_result(input int ci, input int cf, input logic [1:0] ch,
			input logic [1:0] st, input int sv, input bit u, input bit d, input bit l);
		car_result_t r;
		r.car_index = 3'(ci); r.car_floor = 5'(cf); r.heading = ch; r.status = st;
		r.served = 5'(sv); r.upc = u; r.dnc = d; r.last = l;
		pending_results.push_back(r);
	endfunction

	function automatic void add_target(input int c, input logic [4:0] f);
		car_targets[c] |= floor_bit(f);
		if (car_head[c] == HEAD_STOP) begin
			if (f > car_pos[c])
				car_head[c] = HEAD_UP;
			else if (f < car_pos[c])
				car_head[c] = HEAD_DOWN;
		end
	endfunction

	function automatic int pick_car(input logic [4:0] f, input logic [1:0] want);
		int best, best_cost, cost, p;
		bit passed;
		best = 0;
		best_cost = 0;
		for (int i = 0; i < NC; i++) begin
			p = car_pos[i];
			cost = (p > f ? p - f : f - p) * wdist;
			if (car_head[i] == HEAD_STOP) begin
			end else if (car_head[i] == want) begin
				passed = (want == HEAD_UP) ? (f < p) : (f > p);
				if (passed)
					cost += wbehind;
			end else begin
				cost += wopp;
			end
			cost += pop_count(car_targets[i]) * wload;
			if (i == 0 || cost < best_cost) begin
				best_cost = cost;
				best = i;
			end
		end
		return best;
	endfunction

	function automatic void tick_car(input int i);
		logic [4:0] cur;
		logic [1:0] h;
		logic [31:0] tm, above, below;
		bit u, d;
		cur = car_pos[i];
		h = car_head[i];
		u = 0;
		d = 0;
		car_targets[i] &= ~floor_bit(cur);
		if (cur < NF && hall_owner[(cur-1)*2] == i) begin
			hall_owner[(cur-1)*2] = NO_OWNER;
			u = 1;
		end
		if (cur > 1 && hall_owner[(cur-1)*2+1] == i) begin
			hall_owner[(cur-1)*2+1] = NO_OWNER;
			d = 1;
		end
		tm = car_targets[i];
		above = tm & ~((floor_bit(cur) << 1) - 32'd1);
		below = tm & (floor_bit(cur) - 32'd1);
		if (tm == 0)
			h = HEAD_STOP;
		else if ((h == HEAD_UP && above != 0) || (h == HEAD_DOWN && below != 0)) begin
		end else if (h == HEAD_UP && below != 0)
			h = HEAD_DOWN;
		else if (h == HEAD_DOWN && above != 0)
			h = HEAD_UP;
		else if (h == HEAD_STOP)
			h = (below != 0) ? HEAD_DOWN : HEAD_UP;
		car_head[i] = h;
		if (h == HEAD_UP) begin
			if (cur < NF) car_pos[i] = cur + 5'd1;
			else car_head[i] = HEAD_STOP;
		end else if (h == HEAD_DOWN) begin
			if (cur > 1) car_pos[i] = cur - 5'd1;
			else car_head[i] = HEAD_STOP;
		end
		push_result(i, car_pos[i], car_head[i], RS_DONE, cur, u, d, i == NC - 1);
	endfunction

	function automatic void dispatch_step(input op_t op, input logic [4:0] f,
			input logic dir, input logic [2:0] car);
		int slot, owner;
		bit floor_ok;
		floor_ok = f >= 1 && f <= NF;
		if (op == OP_TICK) begin
			for (int i = 0; i < NC; i++)
				tick_car(i);
		end else if (op == OP_CAR_CALL) begin
			if (!floor_ok || car >= NC)
				push_result(0, 0, HEAD_STOP, RS_INVALID, 0, 0, 0, 1);
			else begin
				add_target(car, f);
				push_result(car, car_pos[car], car_head[car], RS_DONE, 0, 0, 0, 1);
			end
		end else if (!floor_ok || (!dir && f == NF) || (dir && f == 1)) begin
			push_result(0, 0, HEAD_STOP, RS_INVALID, 0, 0, 0, 1);
		end else begin
			slot = (f - 1) * 2 + dir;
			owner = hall_owner[slot];
			if (op == OP_HALL_CALL) begin
				if (owner < NC)
					push_result(owner, car_pos[owner], car_head[owner], RS_ASSIGNED,
						0, 0, 0, 1);
				else begin
					owner = pick_car(f, dir ? HEAD_DOWN : HEAD_UP);
					hall_owner[slot] = owner;
					add_target(owner, f);
					push_result(owner, car_pos[owner], car_head[owner], RS_DONE,
						0, 0, 0, 1);
				end
			end else if (owner < NC) begin
				car_targets[owner] &= ~floor_bit(f);
				hall_owner[slot] = NO_OWNER;
				push_result(owner, car_pos[owner], car_head[owner], RS_DONE, 0, 0, 0, 1);
			end else
				push_result(0, 0, HEAD_STOP, RS_NO_CANCEL, 0, 0, 0, 1);
		end
	endfunction

	task automatic write_reg(input reg_idx_t idx, input int val);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= WGT_W'(val);
		@(posedge clk);
		case (idx)
			REG_DIST_W:   wdist = val;
			REG_BEHIND:   wbehind = val;
			REG_OPPOSITE: wopp = val;
			REG_LOAD_W:   wload = val;
			default:      ;
		endcase
	endtask

	task automatic set_weights(input int d, input int b, input int o, input int l);
		write_reg(REG_DIST_W, d);
		write_reg(REG_BEHIND, b);
		write_reg(REG_OPPOSITE, o);
		write_reg(REG_LOAD_W, l);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic send_request(input req_row_t r);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= r.op;
		s_axis_tdata <= {7'd0, r.car, r.dir, r.fl};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		dispatch_step(r.op, r.fl, r.dir, r.car);
		if (r.typed) begin
			void'(pending_results.pop_back());
			pending_results.push_back(r.res);
		end
	endtask

	task automatic drain;
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic req_row_t random_request();
		req_row_t r;
		int k, slot;
		k = $urandom_range(99);
		r.typed = 0;
		r.res = '0;
		r.dir = 1'($urandom_range(1));
		r.car = 3'(($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(NC - 1));
		r.fl = 5'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(NF, 1));
		if (k < 35)
			r.op = OP_HALL_CALL;
		else if (k < 50) begin
			r.op = OP_HALL_CANCEL;
			// aim most cancels at a call that is currently owned
			if ($urandom_range(9) < 6)
				for (int t = 0; t < 12; t++) begin
					slot = $urandom_range(2 * NF - 1);
					if (hall_owner[slot] < NC) begin
						r.fl = 5'(slot / 2 + 1);
						r.dir = 1'(slot % 2);
						break;
					end
				end
		end else if (k < 70)
			r.op = OP_CAR_CALL;
		else
			r.op = OP_TICK;
		return r;
	endfunction

	function automatic void add_row(input op_t op, input int f, input bit d, input int c,
			input bit typed, input int ci, input int cf, input logic [1:0] ch,
			input logic [1:0] st);
		req_row_t r;
		r.op = op; r.fl = 5'(f); r.dir = d; r.car = 3'(c); r.typed = typed;
		r.res = '0;
		r.res.car_index = 3'(ci); r.res.car_floor = 5'(cf); r.res.heading = ch;
		r.res.status = st; r.res.last = 1;
		dir_rows.push_back(r);
	endfunction

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name,
				exp_v, act_v);
		end
	endtask

	// output monitor
	always @(posedge clk) begin
		car_result_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none actual %h", $time,
					m_axis_tdata);
			end else begin
				e = pending_results.pop_front();
				check_field("car_index", e.car_index, m_axis_tdata[2:0]);
				check_field("car_floor", e.car_floor, m_axis_tdata[7:3]);
				check_field("car_heading", e.heading, m_axis_tdata[9:8]);
				check_field("status", e.status, m_axis_tdata[11:10]);
				check_field("served_floor", e.served, m_axis_tdata[16:12]);
				check_field("up_call_cleared", e.upc, m_axis_tdata[17]);
				check_field("down_call_cleared", e.dnc, m_axis_tdata[18]);
				check_field("last", e.last, m_axis_tlast);
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_start)
			hold_left <= 400;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk)
		m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("elevator_group_dispatcher_top regression: fail");
			$finish;
		end
	end

	initial begin
		wdist = DIST_W_RST; wbehind = BEHIND_RST; wopp = OPPOSITE_RST; wload = LOAD_W_RST;
		for (int i = 0; i < NC; i++) begin
			car_pos[i] = 1;
			car_head[i] = HEAD_STOP;
			car_targets[i] = 0;
		end
		for (int k = 0; k < 2 * NF; k++)
			hall_owner[k] = NO_OWNER;

		// after reset every car is equal: tie goes to car 0
		add_row(OP_HALL_CALL, 5, 0, 0, 1, 0, 1, HEAD_UP, RS_DONE);
		add_row(OP_HALL_CALL, 5, 0, 3, 1, 0, 1, HEAD_UP, RS_ASSIGNED);
		add_row(OP_HALL_CALL, 0, 0, 0, 1, 0, 0, HEAD_STOP, RS_INVALID);
		add_row(OP_HALL_CALL, 21, 1, 0, 1, 0, 0, HEAD_STOP, RS_INVALID);
		add_row(OP_HALL_CANCEL, 31, 1, 7, 1, 0, 0, HEAD_STOP, RS_INVALID);
		add_row(OP_HALL_CALL, NF, 0, 0, 1, 0, 0, HEAD_STOP, RS_INVALID);
		add_row(OP_HALL_CALL, 1, 1, 0, 1, 0, 0, HEAD_STOP, RS_INVALID);
		add_row(OP_CAR_CALL, 3, 0, 5, 1, 0, 0, HEAD_STOP, RS_INVALID);
		add_row(OP_CAR_CALL, 3, 1, 7, 1, 0, 0, HEAD_STOP, RS_INVALID);
		add_row(OP_CAR_CALL, 0, 0, 1, 1, 0, 0, HEAD_STOP, RS_INVALID);
		add_row(OP_HALL_CANCEL, 7, 1, 0, 1, 0, 0, HEAD_STOP, RS_NO_CANCEL);
		// car call at own floor while stopped
		add_row(OP_CAR_CALL, 1, 0, 4, 1, 4, 1, HEAD_STOP, RS_DONE);
		add_row(OP_CAR_CALL, NF, 0, 2, 1, 2, 1, HEAD_UP, RS_DONE);
		add_row(OP_HALL_CALL, NF, 1, 0, 0, 0, 0, HEAD_STOP, RS_DONE);
		add_row(OP_HALL_CALL, 1, 0, 0, 0, 0, 0, HEAD_STOP, RS_DONE);
		add_row(OP_TICK, 0, 0, 0, 0, 0, 0, HEAD_STOP, RS_DONE);
		add_row(OP_HALL_CANCEL, 5, 0, 0, 0, 0, 0, HEAD_STOP, RS_DONE);
		add_row(OP_CAR_CALL, 1, 1, 2, 0, 0, 0, HEAD_STOP, RS_DONE);
		add_row(OP_HALL_CALL, 2, 1, 0, 0, 0, 0, HEAD_STOP, RS_DONE);
		add_row(OP_TICK, 0, 0, 0, 0, 0, 0, HEAD_STOP, RS_DONE);
		add_row(OP_TICK, 0, 0, 0, 0, 0, 0, HEAD_STOP, RS_DONE);
		add_row(OP_TICK, 0, 0, 0, 0, 0, 0, HEAD_STOP, RS_DONE);

		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i]);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					set_weights($urandom_range(1023), $urandom_range(1023),
						$urandom_range(1023), $urandom_range(1023));
					idle_pct = 0; stall_pct = 0;
				end
				1: begin
					set_weights(0, 0, 0, 0);
					idle_pct = 83; stall_pct = 0;
				end
				2: begin
					set_weights(1023, 1023, 1023, 1023);
					idle_pct = 0; stall_pct = 83;
				end
				3: begin
					set_weights(DIST_W_RST, BEHIND_RST, OPPOSITE_RST, LOAD_W_RST);
					idle_pct = 23; stall_pct = 23;
					// receiver holds off while requests keep coming
					hold_start <= 1;
					@(posedge clk);
					hold_start <= 0;
				end
				4: begin
					set_weights(0, 1023, 0, 1023);
					idle_pct = 0; stall_pct = 0;
				end
				default: begin
					set_weights($urandom_range(1023), $urandom_range(1023),
						$urandom_range(1023), $urandom_range(1023));
					idle_pct = 23; stall_pct = 23;
				end
			endcase
			for (int n = 0; n < 80; n++)
				send_request(random_request());
			drain();
		end

		if (errors == 0)
			$display("elevator_group_dispatcher_top regression: pass");
		else
			$display("elevator_group_dispatcher_top regression: fail");
		$finish;
	end

endmodule

>>> files.f
hdl/egd_pkg.sv
hdl/egd_ctrl.sv
hdl/egd_datapath.sv
hdl/elevator_group_dispatcher_top.sv
dv/tb.sv
